// File: hdl/sbde_pkg.sv
// shared constants, types and a table function for the split band de-esser
`default_nettype none
package sbde_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int LOG_DEPTH_DEF = 256;

	localparam logic [1:0] MODE_WIDE   = 2'd0;
	localparam logic [1:0] MODE_SPLIT  = 2'd1;
	localparam logic [1:0] MODE_LISTEN = 2'd2;
	localparam logic [1:0] MODE_BYPASS = 2'd3;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_RANGE     = 3'd2;
	localparam logic [2:0] REG_AMOUNT    = 3'd3;
	localparam logic [2:0] REG_ATTACK    = 3'd4;
	localparam logic [2:0] REG_RELEASE   = 3'd5;
	localparam logic [2:0] REG_B0        = 3'd6;
	localparam logic [2:0] REG_A1        = 3'd7;

	localparam logic signed [40:0] S40_MAX = 41'sd549755813887;
	localparam logic signed [40:0] S40_MIN = -41'sd549755813888;
	localparam logic [23:0] ONE_Q23 = 24'd8388608;
	localparam logic [19:0] K_DB_PER_OCT = 20'd394566;
	localparam logic [15:0] K_OVER = 16'd55706;
	localparam logic [13:0] K_OCT_PER_DB = 14'd10886;
	localparam logic [14:0] K_WIDE_DIP = 15'd18350;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_BAND, ST_FEED, ST_ENV, ST_LOG,
		ST_RED, ST_SCALE, ST_GAIN, ST_MIX, ST_OUT
	} state_t;

	// log2(1 + i/depth) in q0.16 by repeated squaring
	function automatic logic [15:0] log_entry(input int i, input int depth);
		logic [63:0] x;
		logic [15:0] v;
		x = (64'd1 << 30) + ((64'(i) << 30) / 64'(depth));
		v = '0;
		for (int b = 0; b < 16; b++) begin
			x = (x * x) >> 30;
			v = {v[14:0], 1'b0};
			if (x >= (64'd1 << 31)) begin
				v[0] = 1'b1;
				x = x >> 1;
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// File: hdl/split_band_de_esser.sv
// split band de-esser top level: per-channel state memory and sequencer
`default_nettype none
// One sample beat of one channel goes in, one processed beat comes out. The
// channel state (two biquad states, envelope and smoothed gain) sits in one
// synchronous memory row per channel, read into a register at the start and
// written back near the end. The sequencer shares one multiplier across its
// steps and finds the gain mantissa by a binary search over the log table,
// one probe per cycle. Bypass mode and channels not below CHANNELS pass the
// sample straight to the output step and leave the state untouched. One beat
// is in flight at a time; a finished result waits in the output register
// while the next beat is accepted, and the sequencer holds in its last step
// while that register is still full. After reset a clearing pass writes the
// reset state into every channel's memory row before the first beat is taken.
module split_band_de_esser #(
	parameter int CHANNELS = sbde_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = sbde_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_DEPTH = sbde_pkg::LOG_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// channel [2:0], sample_in [SAMPLE_BITS+2:3], zero fill to bytes
	input  wire logic [((SAMPLE_BITS+3+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// sample_out [SAMPLE_BITS-1:0], reduction_db [SAMPLE_BITS+12:SAMPLE_BITS], zero fill
	output logic [((SAMPLE_BITS+13+7)/8)*8-1:0] m_tdata,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [23:0] cfg_data
);
	localparam int SB = SAMPLE_BITS;
	localparam int FB = SB - 1;
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LW = $clog2(LOG_TABLE_DEPTH);
	localparam int IW = ((SB + 3 + 7) / 8) * 8;
	localparam int OW = ((SB + 13 + 7) / 8) * 8;
	localparam int RW = 40 + 40 + 24 + 24;
	// coefficient side of the multiplier: 25 bits, or a full sample plus sign
	localparam int MA = (SB + 1 > 25) ? SB + 1 : 25;
	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	// constant log table
	logic [15:0] log_tab [LOG_TABLE_DEPTH];
	always_comb begin
		for (int i = 0; i < LOG_TABLE_DEPTH; i++)
			log_tab[i] = sbde_pkg::log_entry(i, LOG_TABLE_DEPTH);
	end

	// configuration
	logic [1:0] mode_q;
	logic signed [14:0] thr_q;
	logic [12:0] range_q;
	logic [8:0] amount_q;
	logic [23:0] att_q, rel_q;
	logic [22:0] b0_q;
	logic signed [23:0] a1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sbde_pkg::MODE_SPLIT;
			thr_q <= -15'sd7168;
			range_q <= 13'd1792;
			amount_q <= 9'd179;
			att_q <= 24'd16440000;
			rel_q <= 24'd16770000;
			b0_q <= 23'd1900000;
			a1_q <= -24'sd2000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbde_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				sbde_pkg::REG_THRESHOLD: thr_q <= cfg_data[14:0];
				sbde_pkg::REG_RANGE: range_q <= (cfg_data[12:0] > 13'd6144) ?
					13'd6144 : cfg_data[12:0];
				sbde_pkg::REG_AMOUNT: amount_q <= (cfg_data[8:0] > 9'd256) ?
					9'd256 : cfg_data[8:0];
				sbde_pkg::REG_ATTACK: att_q <= cfg_data;
				sbde_pkg::REG_RELEASE: rel_q <= cfg_data;
				sbde_pkg::REG_B0: b0_q <= (cfg_data[22:0] > 23'd4194304) ?
					23'd4194304 : cfg_data[22:0];
				sbde_pkg::REG_A1: a1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sbde_pkg::state_t st_q, st_nx;
	logic [CW-1:0] ch_q;
	logic signed [SB-1:0] dry_q;
	logic signed [39:0] s1_q, s2_q;
	logic [23:0] env_q, gain_q;
	logic signed [39:0] y_q;
	logic signed [SB-1:0] sb_q;
	logic signed [63:0] acc_q;
	logic [LW:0] lo_q, hi_q;
	logic [5:0] p_q;
	logic signed [23:0] over_q;
	logic [12:0] red_q;
	logic [23:0] target_q;
	logic [1:0] sub_q;
	logic [SB-1:0] res_s_q;
	logic [12:0] res_r_q;
	logic out_full_q;
	logic [SB-1:0] out_s_q;
	logic [12:0] out_r_q;

	// channel state memory: {s1, s2, env, gain}
	logic [RW-1:0] mem [CHANNELS];
	logic [RW-1:0] rd_q;
	logic mem_we;
	logic [CW-1:0] mem_wa;
	logic [RW-1:0] mem_wd;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[ch_q];
	end

	// clearing pass
	logic clr_q;
	logic [CW:0] clr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (CW+1)'(CHANNELS - 1)) clr_q <= 1'b0;
		end
	end

	wire in_acc = s_tvalid && s_tready;
	wire out_free = !out_full_q || m_tready;
	assign s_tready = (st_q == sbde_pkg::ST_IDLE) && !clr_q;
	assign m_tvalid = out_full_q;
	assign m_tdata = OW'({out_r_q, out_s_q});

	wire [2:0] in_ch = s_tdata[2:0];
	wire signed [SB-1:0] in_smp = s_tdata[SB+2:3];
	wire in_bypass = (32'(in_ch) >= CHANNELS) || (mode_q == sbde_pkg::MODE_BYPASS);

	// shared helpers
	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		if (v > 64'(sbde_pkg::S40_MAX)) return sbde_pkg::S40_MAX[39:0];
		if (v < 64'(sbde_pkg::S40_MIN)) return sbde_pkg::S40_MIN[39:0];
		return v[39:0];
	endfunction
	function automatic logic signed [SB-1:0] satsb(input logic signed [63:0] v);
		if (v > 64'(SMAX)) return SMAX;
		if (v < 64'(SMIN)) return SMIN;
		return v[SB-1:0];
	endfunction

	// the shared signed multiplier and its operands
	logic signed [MA-1:0] mul_a;
	logic signed [40:0] mul_b;
	logic signed [63:0] prod;
	assign prod = 64'(mul_a) * 64'(mul_b);

	wire signed [40:0] xs = 41'(dry_q) <<< (31 - FB);
	wire signed [24:0] a2 = 25'(sbde_pkg::ONE_Q23) - 25'({b0_q, 1'b0});
	wire [23:0] det23 = (FB >= 23) ? 24'(33'(sb_q < 0 ? -33'(sb_q) : 33'(sb_q)) >> (FB-23))
		: 24'(33'(sb_q < 0 ? -33'(sb_q) : 33'(sb_q)) << (23-FB));
	wire [23:0] det_c = (det23 > 24'h7FFFFF) ? 24'h7FFFFF : det23;
	wire [23:0] env_fl = (env_q < 24'd8) ? 24'd8 : env_q;
	wire [LW:0] mid = (lo_q + hi_q + 1'b1) >> 1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			sbde_pkg::ST_BAND: begin mul_a = MA'(b0_q); mul_b = xs; end
			sbde_pkg::ST_FEED: begin
				if (sub_q == 2'd0) begin mul_a = -MA'(a1_q); mul_b = 41'(y_q); end
				else begin mul_a = MA'(a2); mul_b = 41'(y_q); end
			end
			sbde_pkg::ST_MIX: begin
				if (sub_q == 2'd0) begin mul_a = MA'(sb_q); mul_b = 41'(gain_q); end
				else begin mul_a = MA'(dry_q); mul_b = acc_q[40:0]; end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			sbde_pkg::ST_IDLE: if (in_acc && !in_bypass) st_nx = sbde_pkg::ST_READ;
				else if (in_acc) st_nx = sbde_pkg::ST_OUT;
			sbde_pkg::ST_READ: st_nx = sbde_pkg::ST_BAND;
			sbde_pkg::ST_BAND: st_nx = sbde_pkg::ST_FEED;
			sbde_pkg::ST_FEED: if (sub_q == 2'd2) st_nx = sbde_pkg::ST_ENV;
			sbde_pkg::ST_ENV: st_nx = sbde_pkg::ST_LOG;
			sbde_pkg::ST_LOG: if (sub_q == 2'd1) st_nx = sbde_pkg::ST_RED;
			sbde_pkg::ST_RED: if (sub_q == 2'd3) st_nx = sbde_pkg::ST_SCALE;
			sbde_pkg::ST_SCALE: if (lo_q >= hi_q) st_nx = sbde_pkg::ST_GAIN;
			sbde_pkg::ST_GAIN: st_nx = sbde_pkg::ST_MIX;
			sbde_pkg::ST_MIX: if (sub_q == 2'd2) st_nx = sbde_pkg::ST_OUT;
			sbde_pkg::ST_OUT: if (out_free) st_nx = sbde_pkg::ST_IDLE;
			default: st_nx = sbde_pkg::ST_IDLE;
		endcase
	end

	// memory write back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ch_q;
		mem_wd = {s1_q, s2_q, env_q, gain_q};
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q[CW-1:0];
			mem_wd = {40'd0, 40'd0, 24'd0, sbde_pkg::ONE_Q23};
		end else if (st_q == sbde_pkg::ST_MIX && sub_q == 2'd0) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sbde_pkg::ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == sbde_pkg::ST_OUT && out_free) out_full_q <= 1'b1;
			else if (m_tready) out_full_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic signed [63:0] t;
		logic [49:0] sm;
		logic [23:0] c;
		logic [LW:0] idx;
		logic signed [63:0] l16;
		logic signed [31:0] e;
		logic [5:0] k;
		logic [5:0] pv;
		logic [15:0] f;
		unique case (st_q)
			sbde_pkg::ST_IDLE: begin
				sub_q <= '0;
				ch_q <= CW'(in_ch);
				dry_q <= in_smp;
				if (in_acc) begin
					res_s_q <= in_smp;
					res_r_q <= '0;
				end
			end
			sbde_pkg::ST_READ: ;
			sbde_pkg::ST_BAND: begin
				{s1_q, s2_q, env_q, gain_q} <= rd_q;
				acc_q <= prod;
				y_q <= sat40(((prod + 64'sd4194304) >>> 23) + 64'(signed'(rd_q[127:88])));
			end
			sbde_pkg::ST_FEED: begin
				sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
				if (sub_q == 2'd0)
					s1_q <= sat40(((prod + 64'sd2097152) >>> 22) + 64'(s2_q));
				else if (sub_q == 2'd1)
					s2_q <= sat40((-acc_q - prod + 64'sd4194304) >>> 23);
				else begin
					t = (FB == 31) ? 64'(y_q) : ((64'(y_q) + (64'sd1 <<< (30-FB))) >>> (31-FB));
					sb_q <= satsb(t);
				end
			end
			sbde_pkg::ST_ENV: begin
				c = (det_c > env_q) ? att_q : rel_q;
				sm = 50'(c) * 50'(env_q) + (50'd1 << 24) * 50'(det_c) - 50'(c) * 50'(det_c)
					+ (50'd1 << 23);
				env_q <= sm[47:24];
				p_q <= '0;
			end
			sbde_pkg::ST_LOG: begin
				sub_q <= (sub_q == 2'd1) ? 2'd0 : sub_q + 2'd1;
				if (sub_q == 2'd0) begin
					// leading one of the floored envelope
					pv = '0;
					for (int i = 0; i < 24; i++) if (env_fl[i]) pv = 6'(i);
					p_q <= pv;
				end else begin
					idx = (LW+1)'((48'(env_fl - (24'd1 << p_q)) << LW) >> p_q);
					if (idx >= (LW+1)'(LOG_TABLE_DEPTH)) idx = (LW+1)'(LOG_TABLE_DEPTH - 1);
					l16 = (64'(signed'({1'b0, p_q})) - 64'sd23) * 64'sd65536
						+ 64'(log_tab[idx[LW-1:0]]);
					acc_q <= l16;
				end
			end
			sbde_pkg::ST_RED: begin
				sub_q <= sub_q + 2'd1;
				if (sub_q == 2'd0) begin
					t = (acc_q * 64'sd394566 + 64'sd8388608) >>> 24;
					t = t - 64'(thr_q);
					over_q <= (t < 0) ? '0 : t[23:0];
				end else if (sub_q == 2'd1) begin
					t = (64'(over_q) * 64'sd55706 + 64'sd32768) >>> 16;
					if (t > 64'(range_q)) t = 64'(range_q);
					red_q <= t[12:0];
				end else if (sub_q == 2'd2) begin
					t = (64'(red_q) * 64'(amount_q) + 64'sd128) >>> 8;
					red_q <= t[12:0];
				end else begin
					// gain exponent in q16 octaves
					e = 32'((64'(red_q) * 64'sd10886 + 64'sd128) >>> 8);
					acc_q <= 64'(e);
					lo_q <= '0;
					hi_q <= (LW+1)'(LOG_TABLE_DEPTH - 1);
				end
			end
			sbde_pkg::ST_SCALE: begin
				f = acc_q[15:0];
				k = 6'(acc_q[31:16]);
				if (lo_q < hi_q) begin
					if (17'(log_tab[mid[LW-1:0]]) <= 17'd65536 - 17'(f)) lo_q <= mid;
					else hi_q <= mid - 1'b1;
				end else if (acc_q[31:16] > 16'd23) target_q <= '0;
				else if (f == 16'd0) target_q <= sbde_pkg::ONE_Q23 >> k;
				else target_q <= 24'((48'(sbde_pkg::ONE_Q23) + ((48'(lo_q) << 23) >> LW))
					>> (k + 6'd1));
			end
			sbde_pkg::ST_GAIN: begin
				c = (target_q < gain_q) ? att_q : rel_q;
				sm = 50'(c) * 50'(gain_q) + (50'd1 << 24) * 50'(target_q)
					- 50'(c) * 50'(target_q) + (50'd1 << 23);
				gain_q <= sm[47:24];
			end
			sbde_pkg::ST_MIX: begin
				sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
				if (sub_q == 2'd0) begin
					y_q <= 40'((prod + 64'sd4194304) >>> 23);
					t = 64'sd8388608 - ((64'sd18350 * (64'sd8388608 - 64'(gain_q))
						+ 64'sd32768) >>> 16);
					acc_q <= t;
				end else if (sub_q == 2'd1) begin
					if (mode_q == sbde_pkg::MODE_LISTEN) t = 64'(y_q);
					else if (mode_q == sbde_pkg::MODE_WIDE) t = (prod + 64'sd4194304) >>> 23;
					else t = 64'(dry_q) + 64'(y_q) - 64'(sb_q);
					res_s_q <= satsb(t);
					res_r_q <= red_q;
				end
			end
			sbde_pkg::ST_OUT: begin
				// load the output register only once it is free
				if (out_free) begin
					out_s_q <= res_s_q;
					out_r_q <= res_r_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
